FILE: rtl/nmcs_pkg.sv
// shared types and constants for the nearest marker cluster selector
`default_nettype none

package nmcs_pkg;

    // field widths
    localparam int ID_W     = 10;
    localparam int POS_W    = 16;
    localparam int ROT_W    = 16;
    localparam int TEAM_W   = 11;
    localparam int RADIUS_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // one stored marker: {id, pos x, pos y, pos z, rot x, rot y, rot z}
    localparam int WORD_W = ID_W + 3 * POS_W + 3 * ROT_W;
    localparam int ROT_Z_LSB = 0;
    localparam int ROT_Y_LSB = ROT_Z_LSB + ROT_W;
    localparam int ROT_X_LSB = ROT_Y_LSB + ROT_W;
    localparam int POS_Z_LSB = ROT_X_LSB + ROT_W;
    localparam int POS_Y_LSB = POS_Z_LSB + POS_W;
    localparam int POS_X_LSB = POS_Y_LSB + POS_W;
    localparam int ID_LSB    = POS_X_LSB + POS_W;

    // distance arithmetic
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int R2_W   = 2 * RADIUS_W;
    localparam int D2_W   = SQ_W + 2;

    // reset values
    localparam logic [RADIUS_W-1:0]     RADIUS_RESET = 16'd300;
    localparam logic [TEAM_W-1:0]       TEAM_RESET   = 11'h7FF;
    localparam logic signed [POS_W-1:0] DEPTH_MAX    = 16'sh7FFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_TEAM_A = 2'd1,
        CFG_TEAM_B = 2'd2
    } cfg_idx_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_ANCHOR = 2'd0,
        RD_SCAN   = 2'd1,
        RD_BEST   = 2'd2
    } rd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    anchor_ld;
        logic    dist_issue;
        logic    best_clear;
        logic    scan_step;
        logic    emit_found;
        logic    emit_none;
        logic    frame_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last_scan;
        logic dist_busy;
        logic cand_zero;
        logic out_free;
        logic sel_final;
    } stat_t;

    // a negative team id matches nothing
    function automatic logic team_match(input logic [ID_W-1:0] id,
                                        input logic [TEAM_W-1:0] team);
        team_match = !team[TEAM_W-1] && (team[ID_W-1:0] == id);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nearest_marker_cluster_select.sv
// top level of the nearest marker cluster selector
`default_nettype none

// Markers of one frame are loaded one per cycle while in_stall is low; the
// item with frame_end set closes the frame and the input then stalls until
// the frame's last result has gone into the output register. Selection runs
// off the single read port of the marker store: an anchor read, a distance
// pass over the N stored markers, and for each of the K results a ranking
// scan and a fetch of the selected marker. An empty frame or no match gives
// one result with found low. Results wait in an output register, so loading
// of the next frame overlaps with the last result being taken.
module nearest_marker_cluster_select #(
    parameter int MAX_MARKERS  = 16,
    parameter int MAX_SELECTED = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [nmcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nmcs_pkg::CFG_W-1:0]         cfg_data,
    // marker input
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [nmcs_pkg::ID_W-1:0]          marker_id,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]  pos_y,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]  pos_z,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]  rot_x,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]  rot_y,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]  rot_z,
    input  wire logic                               frame_end,
    input  wire logic                               empty_frame,
    // selection output
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [nmcs_pkg::ID_W-1:0]               sel_id,
    output logic signed [nmcs_pkg::POS_W-1:0]       sel_pos_x,
    output logic signed [nmcs_pkg::POS_W-1:0]       sel_pos_y,
    output logic signed [nmcs_pkg::POS_W-1:0]       sel_pos_z,
    output logic signed [nmcs_pkg::ROT_W-1:0]       sel_rot_x,
    output logic signed [nmcs_pkg::ROT_W-1:0]       sel_rot_y,
    output logic signed [nmcs_pkg::ROT_W-1:0]       sel_rot_z,
    output logic                                    found,
    output logic                                    last_sel
);

    localparam int IW = $clog2(MAX_MARKERS);

    nmcs_pkg::cmd_t  cmd;
    nmcs_pkg::stat_t stat;
    logic [IW-1:0]   scan_idx;

    // sequencing
    nmcs_ctrl #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    // storage and arithmetic
    nmcs_dp #(
        .MAX_MARKERS  (MAX_MARKERS),
        .MAX_SELECTED (MAX_SELECTED)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .scan_idx    (scan_idx),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .marker_id   (marker_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .rot_x       (rot_x),
        .rot_y       (rot_y),
        .rot_z       (rot_z),
        .empty_frame (empty_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sel_id      (sel_id),
        .sel_pos_x   (sel_pos_x),
        .sel_pos_y   (sel_pos_y),
        .sel_pos_z   (sel_pos_z),
        .sel_rot_x   (sel_rot_x),
        .sel_rot_y   (sel_rot_y),
        .sel_rot_z   (sel_rot_z),
        .found       (found),
        .last_sel    (last_sel)
    );

endmodule

`default_nettype wire

FILE: rtl/nmcs_ram.sv
// generic single write, single read ram with registered read
`default_nettype none

module nmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/nmcs_ctrl.sv
// sequencing state machine for the nearest marker cluster selector
`default_nettype none

module nmcs_ctrl #(
    parameter int MAX_MARKERS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           frame_end,
    output logic                                in_stall,
    input  wire nmcs_pkg::stat_t                stat,
    output nmcs_pkg::cmd_t                      cmd,
    output logic [$clog2(MAX_MARKERS)-1:0]      scan_idx
);

    localparam int IW = $clog2(MAX_MARKERS);

    typedef enum logic [8:0] {
        S_LOAD      = 9'b000000001,
        S_ANCHOR_RD = 9'b000000010,
        S_ANCHOR_LD = 9'b000000100,
        S_DIST      = 9'b000001000,
        S_DRAIN     = 9'b000010000,
        S_SCAN      = 9'b000100000,
        S_FETCH     = 9'b001000000,
        S_EMIT      = 9'b010000000,
        S_NONE      = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    assign scan_idx = idx_reg;
    assign in_stall = (state_reg != S_LOAD);

    // state and index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.rd_sel = nmcs_pkg::RD_SCAN;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (frame_end)
                    begin
                        state_next = S_ANCHOR_RD;
                    end
                end
            end
            S_ANCHOR_RD:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_NONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = nmcs_pkg::RD_ANCHOR;
                    state_next = S_ANCHOR_LD;
                end
            end
            S_ANCHOR_LD:
            begin
                cmd.anchor_ld = 1'b1;
                idx_next      = '0;
                state_next    = S_DIST;
            end
            S_DIST:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = nmcs_pkg::RD_SCAN;
                cmd.dist_issue = 1'b1;
                if (stat.last_scan)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!stat.dist_busy)
                begin
                    if (stat.cand_zero)
                    begin
                        state_next = S_NONE;
                    end
                    else
                    begin
                        cmd.best_clear = 1'b1;
                        idx_next       = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.last_scan)
                begin
                    idx_next   = '0;
                    state_next = S_FETCH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = nmcs_pkg::RD_BEST;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_found = 1'b1;
                    if (stat.sel_final)
                    begin
                        cmd.frame_clear = 1'b1;
                        state_next      = S_LOAD;
                    end
                    else
                    begin
                        cmd.best_clear = 1'b1;
                        idx_next       = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_none   = 1'b1;
                    cmd.frame_clear = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/nmcs_dp.sv
// marker store, distance pipeline, ranking scan and output register
`default_nettype none

module nmcs_dp #(
    parameter int MAX_MARKERS  = 16,
    parameter int MAX_SELECTED = 4
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire nmcs_pkg::cmd_t                           cmd,
    input  wire logic [$clog2(MAX_MARKERS)-1:0]           scan_idx,
    output nmcs_pkg::stat_t                               stat,
    // configuration
    input  wire logic                                     cfg_we,
    input  wire logic [nmcs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [nmcs_pkg::CFG_W-1:0]               cfg_data,
    // input item
    input  wire logic [nmcs_pkg::ID_W-1:0]                marker_id,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]        pos_x,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]        pos_y,
    input  wire logic signed [nmcs_pkg::POS_W-1:0]        pos_z,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]        rot_x,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]        rot_y,
    input  wire logic signed [nmcs_pkg::ROT_W-1:0]        rot_z,
    input  wire logic                                     empty_frame,
    // result
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic [nmcs_pkg::ID_W-1:0]                     sel_id,
    output logic signed [nmcs_pkg::POS_W-1:0]             sel_pos_x,
    output logic signed [nmcs_pkg::POS_W-1:0]             sel_pos_y,
    output logic signed [nmcs_pkg::POS_W-1:0]             sel_pos_z,
    output logic signed [nmcs_pkg::ROT_W-1:0]             sel_rot_x,
    output logic signed [nmcs_pkg::ROT_W-1:0]             sel_rot_y,
    output logic signed [nmcs_pkg::ROT_W-1:0]             sel_rot_z,
    output logic                                          found,
    output logic                                          last_sel
);

    localparam int IW = $clog2(MAX_MARKERS);
    localparam int CW = $clog2(MAX_MARKERS + 1);
    localparam int SW = $clog2(MAX_SELECTED + 1);
    localparam int KW = ((CW > SW) ? CW : SW) + 1;

    localparam int ID_W   = nmcs_pkg::ID_W;
    localparam int POS_W  = nmcs_pkg::POS_W;
    localparam int ROT_W  = nmcs_pkg::ROT_W;
    localparam int WORD_W = nmcs_pkg::WORD_W;
    localparam int DIFF_W = nmcs_pkg::DIFF_W;
    localparam int SQ_W   = nmcs_pkg::SQ_W;
    localparam int R2_W   = nmcs_pkg::R2_W;
    localparam int D2_W   = nmcs_pkg::D2_W;

    // configuration registers
    logic [nmcs_pkg::RADIUS_W-1:0] radius_reg;
    logic [nmcs_pkg::TEAM_W-1:0]   team_a_reg;
    logic [nmcs_pkg::TEAM_W-1:0]   team_b_reg;
    logic [R2_W-1:0]               r2_reg;

    // frame bookkeeping
    logic [CW-1:0]                 count_reg;
    logic [IW-1:0]                 anchor_idx_reg;
    logic signed [POS_W-1:0]       anchor_depth_reg;
    logic [CW-1:0]                 cand_cnt_reg;
    logic [SW-1:0]                 sel_cnt_reg;

    // anchor position
    logic signed [POS_W-1:0]       anc_x_reg, anc_y_reg, anc_z_reg;

    // distance pipeline
    logic                          v0_reg, v1_reg, v2_reg;
    logic [IW-1:0]                 idx0_reg, idx1_reg, idx2_reg;
    logic                          match1_reg, match2_reg;
    logic signed [DIFF_W-1:0]      dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]               sqx_reg, sqy_reg, sqz_reg;

    // per marker distance and candidate flag
    logic [D2_W-1:0]               d2_arr_reg [MAX_MARKERS];
    logic                          cand_arr_reg [MAX_MARKERS];

    // ranking scan
    logic                          best_valid_reg;
    logic [D2_W-1:0]               best_d2_reg;
    logic [IW-1:0]                 best_idx_reg;
    logic                          prev_valid_reg;
    logic [D2_W-1:0]               prev_d2_reg;
    logic [IW-1:0]                 prev_idx_reg;

    // output register
    logic                          out_valid_reg;
    logic [ID_W-1:0]               sel_id_reg;
    logic signed [POS_W-1:0]       sel_px_reg, sel_py_reg, sel_pz_reg;
    logic signed [ROT_W-1:0]       sel_rx_reg, sel_ry_reg, sel_rz_reg;
    logic                          found_reg;
    logic                          last_reg;

    // store ports
    logic                          st_wr_en;
    logic [IW-1:0]                 st_rd_addr;
    logic [WORD_W-1:0]             st_wr_data;
    logic [WORD_W-1:0]             st_rd_data;

    logic [ID_W-1:0]               rd_id;
    logic signed [POS_W-1:0]       rd_px, rd_py, rd_pz;
    logic signed [ROT_W-1:0]       rd_rx, rd_ry, rd_rz;

    logic signed [2*DIFF_W-1:0]    sqx_full, sqy_full, sqz_full;
    logic [D2_W-1:0]               d2_sum;
    logic                          in_radius;
    logic                          store_full;

    logic [D2_W-1:0]               cur_d2;
    logic                          cur_cand;
    logic                          after_prev;
    logic                          beats_best;

    // store write on a marker transfer with room left
    assign store_full = (count_reg == CW'(MAX_MARKERS));
    assign st_wr_en   = cmd.load && !empty_frame && !store_full;
    assign st_wr_data = {marker_id, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z};

    // read address source
    always_comb
    begin
        case (cmd.rd_sel)
            nmcs_pkg::RD_ANCHOR: st_rd_addr = anchor_idx_reg;
            nmcs_pkg::RD_BEST:   st_rd_addr = best_idx_reg;
            default:             st_rd_addr = scan_idx;
        endcase
    end

    nmcs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_MARKERS)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (st_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // unpack the read word
    assign rd_id = st_rd_data[nmcs_pkg::ID_LSB +: ID_W];
    assign rd_px = $signed(st_rd_data[nmcs_pkg::POS_X_LSB +: POS_W]);
    assign rd_py = $signed(st_rd_data[nmcs_pkg::POS_Y_LSB +: POS_W]);
    assign rd_pz = $signed(st_rd_data[nmcs_pkg::POS_Z_LSB +: POS_W]);
    assign rd_rx = $signed(st_rd_data[nmcs_pkg::ROT_X_LSB +: ROT_W]);
    assign rd_ry = $signed(st_rd_data[nmcs_pkg::ROT_Y_LSB +: ROT_W]);
    assign rd_rz = $signed(st_rd_data[nmcs_pkg::ROT_Z_LSB +: ROT_W]);

    // configuration writes and squared radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= nmcs_pkg::RADIUS_RESET;
            team_a_reg <= nmcs_pkg::TEAM_RESET;
            team_b_reg <= nmcs_pkg::TEAM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nmcs_pkg::CFG_RADIUS: radius_reg <= cfg_data[nmcs_pkg::RADIUS_W-1:0];
                nmcs_pkg::CFG_TEAM_A: team_a_reg <= cfg_data[nmcs_pkg::TEAM_W-1:0];
                nmcs_pkg::CFG_TEAM_B: team_b_reg <= cfg_data[nmcs_pkg::TEAM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= radius_reg * radius_reg;
    end

    // marker count and running anchor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            anchor_idx_reg   <= '0;
            anchor_depth_reg <= nmcs_pkg::DEPTH_MAX;
        end
        else if (cmd.frame_clear)
        begin
            count_reg        <= '0;
            anchor_idx_reg   <= '0;
            anchor_depth_reg <= nmcs_pkg::DEPTH_MAX;
        end
        else if (st_wr_en)
        begin
            count_reg <= count_reg + CW'(1);
            if ((count_reg == '0) || (pos_z < anchor_depth_reg))
            begin
                anchor_depth_reg <= pos_z;
                anchor_idx_reg   <= count_reg[IW-1:0];
            end
        end
    end

    // anchor position capture
    always_ff @(posedge clk)
    begin
        if (cmd.anchor_ld)
        begin
            anc_x_reg <= rd_px;
            anc_y_reg <= rd_py;
            anc_z_reg <= rd_pz;
        end
    end

    // distance pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.dist_issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign sqz_full = dz_reg * dz_reg;

    // distance pipeline data: difference, square
    always_ff @(posedge clk)
    begin
        idx0_reg   <= scan_idx;
        idx1_reg   <= idx0_reg;
        idx2_reg   <= idx1_reg;
        dx_reg     <= DIFF_W'(rd_px) - DIFF_W'(anc_x_reg);
        dy_reg     <= DIFF_W'(rd_py) - DIFF_W'(anc_y_reg);
        dz_reg     <= DIFF_W'(rd_pz) - DIFF_W'(anc_z_reg);
        match1_reg <= nmcs_pkg::team_match(rd_id, team_a_reg)
                   || nmcs_pkg::team_match(rd_id, team_b_reg);
        match2_reg <= match1_reg;
        sqx_reg    <= sqx_full[SQ_W-1:0];
        sqy_reg    <= sqy_full[SQ_W-1:0];
        sqz_reg    <= sqz_full[SQ_W-1:0];
    end

    // sum of squares against squared radius
    assign d2_sum    = D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
    assign in_radius = (d2_sum <= D2_W'(r2_reg));

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            d2_arr_reg[idx2_reg]   <= d2_sum;
            cand_arr_reg[idx2_reg] <= in_radius && match2_reg;
        end
    end

    // candidate count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_cnt_reg <= '0;
        end
        else if (cmd.frame_clear)
        begin
            cand_cnt_reg <= '0;
        end
        else if (v2_reg && in_radius && match2_reg)
        begin
            cand_cnt_reg <= cand_cnt_reg + CW'(1);
        end
    end

    // ranking: smallest (distance, index) above the last one emitted
    assign cur_d2     = d2_arr_reg[scan_idx];
    assign cur_cand   = cand_arr_reg[scan_idx];
    assign after_prev = !prev_valid_reg || (cur_d2 > prev_d2_reg)
                     || ((cur_d2 == prev_d2_reg) && (scan_idx > prev_idx_reg));
    assign beats_best = !best_valid_reg || (cur_d2 < best_d2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            sel_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.best_clear)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step && cur_cand && after_prev && beats_best)
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.frame_clear)
            begin
                prev_valid_reg <= 1'b0;
                sel_cnt_reg    <= '0;
            end
            else if (cmd.emit_found)
            begin
                prev_valid_reg <= 1'b1;
                sel_cnt_reg    <= sel_cnt_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && cur_cand && after_prev && beats_best)
        begin
            best_d2_reg  <= cur_d2;
            best_idx_reg <= scan_idx;
        end
        if (cmd.emit_found)
        begin
            prev_d2_reg  <= best_d2_reg;
            prev_idx_reg <= best_idx_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_found || cmd.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_found)
        begin
            sel_id_reg <= rd_id;
            sel_px_reg <= rd_px;
            sel_py_reg <= rd_py;
            sel_pz_reg <= rd_pz;
            sel_rx_reg <= rd_rx;
            sel_ry_reg <= rd_ry;
            sel_rz_reg <= rd_rz;
            found_reg  <= 1'b1;
            last_reg   <= stat.sel_final;
        end
        else if (cmd.emit_none)
        begin
            sel_id_reg <= '0;
            sel_px_reg <= '0;
            sel_py_reg <= '0;
            sel_pz_reg <= '0;
            sel_rx_reg <= '0;
            sel_ry_reg <= '0;
            sel_rz_reg <= '0;
            found_reg  <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign sel_id    = sel_id_reg;
    assign sel_pos_x = sel_px_reg;
    assign sel_pos_y = sel_py_reg;
    assign sel_pos_z = sel_pz_reg;
    assign sel_rot_x = sel_rx_reg;
    assign sel_rot_y = sel_ry_reg;
    assign sel_rot_z = sel_rz_reg;
    assign found     = found_reg;
    assign last_sel  = last_reg;

    // status to the controller
    always_comb
    begin
        stat            = '0;
        stat.count_zero = (count_reg == '0);
        stat.last_scan  = ((CW'(scan_idx) + CW'(1)) == count_reg);
        stat.dist_busy  = v0_reg || v1_reg || v2_reg;
        stat.cand_zero  = (cand_cnt_reg == '0);
        stat.out_free   = !out_valid_reg || !out_stall;
        stat.sel_final  = ((KW'(sel_cnt_reg) + KW'(1)) == KW'(MAX_SELECTED))
                       || ((KW'(sel_cnt_reg) + KW'(1)) == KW'(cand_cnt_reg));
    end

endmodule

`default_nettype wire

FILE: dv/tb_nearest_marker_cluster_select.sv
// testbench for the nearest marker cluster selector: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_nearest_marker_cluster_select;

    import nmcs_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int PICK_LIMIT   = 4;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PRINT_LIMIT  = 200;
    // index past the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
        logic                    fend;
        logic                    empty;
    } marker_t;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
        logic                    found;
        logic                    last;
    } sel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ID_W-1:0]         marker_id = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic signed [ROT_W-1:0] rot_x = '0;
    logic signed [ROT_W-1:0] rot_y = '0;
    logic signed [ROT_W-1:0] rot_z = '0;
    logic                    frame_end = 1'b0;
    logic                    empty_frame = 1'b0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ID_W-1:0]         sel_id;
    logic signed [POS_W-1:0] sel_pos_x;
    logic signed [POS_W-1:0] sel_pos_y;
    logic signed [POS_W-1:0] sel_pos_z;
    logic signed [ROT_W-1:0] sel_rot_x;
    logic signed [ROT_W-1:0] sel_rot_y;
    logic signed [ROT_W-1:0] sel_rot_z;
    logic                    found;
    logic                    last_sel;

    // stimulus and expectations
    marker_t marker_queue[$];
    marker_t marker_on_bus;
    sel_t    expected_sel[$];
    sel_t    sel_due;
    int      items_queued = 0;
    int      items_taken = 0;
    int      error_count = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // predictor state
    marker_t               frame_store[STORE_DEPTH];
    int                    stored_count = 0;
    int                    anchor_slot = 0;
    logic signed [POS_W-1:0] anchor_z = DEPTH_MAX;
    logic [RADIUS_W-1:0]   radius_cfg = RADIUS_RESET;
    logic [TEAM_W-1:0]     team_a_cfg = TEAM_RESET;
    logic [TEAM_W-1:0]     team_b_cfg = TEAM_RESET;

    nearest_marker_cluster_select u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .marker_id   (marker_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .rot_x       (rot_x),
        .rot_y       (rot_y),
        .rot_z       (rot_z),
        .frame_end   (frame_end),
        .empty_frame (empty_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sel_id      (sel_id),
        .sel_pos_x   (sel_pos_x),
        .sel_pos_y   (sel_pos_y),
        .sel_pos_z   (sel_pos_z),
        .sel_rot_x   (sel_rot_x),
        .sel_rot_y   (sel_rot_y),
        .sel_rot_z   (sel_rot_z),
        .found       (found),
        .last_sel    (last_sel)
    );

    always #5 clk = ~clk;

    // negative team ids never match
    function automatic bit team_hits(logic [ID_W-1:0] id, logic [TEAM_W-1:0] team);
        team_hits = !team[TEAM_W-1] && (team[ID_W-1:0] == id);
    endfunction

    // store one marker, and on frame end rank the cluster and queue the picks
    function automatic void predict_selection(marker_t m);
        int      cand_slot[STORE_DEPTH];
        longint  cand_dist[STORE_DEPTH];
        int      pick_slot[PICK_LIMIT];
        int      n_cand;
        int      n_pick;
        int      k;
        longint  dx;
        longint  dy;
        longint  dz;
        longint  d2;
        longint  r2;
        sel_t    s;
        n_cand = 0;
        n_pick = 0;
        if (!m.empty && stored_count < STORE_DEPTH)
        begin
            frame_store[stored_count] = m;
            if (stored_count == 0 || m.pz < anchor_z)
            begin
                anchor_z = m.pz;
                anchor_slot = stored_count;
            end
            stored_count++;
        end
        if (!m.fend)
            return;
        r2 = longint'(radius_cfg) * longint'(radius_cfg);
        // cluster members, stable sort by squared distance
        for (int i = 0; i < stored_count; i++)
        begin
            dx = longint'(frame_store[i].px) - longint'(frame_store[anchor_slot].px);
            dy = longint'(frame_store[i].py) - longint'(frame_store[anchor_slot].py);
            dz = longint'(frame_store[i].pz) - longint'(frame_store[anchor_slot].pz);
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 <= r2)
            begin
                k = n_cand;
                while (k > 0 && cand_dist[k-1] > d2)
                begin
                    cand_dist[k] = cand_dist[k-1];
                    cand_slot[k] = cand_slot[k-1];
                    k--;
                end
                cand_dist[k] = d2;
                cand_slot[k] = i;
                n_cand++;
            end
        end
        // team filter, nearest first
        for (int i = 0; i < n_cand && n_pick < PICK_LIMIT; i++)
        begin
            if (team_hits(frame_store[cand_slot[i]].id, team_a_cfg) ||
                team_hits(frame_store[cand_slot[i]].id, team_b_cfg))
            begin
                pick_slot[n_pick] = cand_slot[i];
                n_pick++;
            end
        end
        if (n_pick == 0)
        begin
            s = '{default: '0};
            s.last = 1'b1;
            expected_sel.insert(expected_sel.size(), s);
        end
        for (int i = 0; i < n_pick; i++)
        begin
            s.id    = frame_store[pick_slot[i]].id;
            s.px    = frame_store[pick_slot[i]].px;
            s.py    = frame_store[pick_slot[i]].py;
            s.pz    = frame_store[pick_slot[i]].pz;
            s.rx    = frame_store[pick_slot[i]].rx;
            s.ry    = frame_store[pick_slot[i]].ry;
            s.rz    = frame_store[pick_slot[i]].rz;
            s.found = 1'b1;
            s.last  = (i == n_pick - 1);
            expected_sel.insert(expected_sel.size(), s);
        end
        stored_count = 0;
        anchor_slot = 0;
        anchor_z = DEPTH_MAX;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic [15:0] rand16();
        rand16 = 16'($urandom_range(65535));
    endfunction

    function automatic marker_t mk(int id, int px, int py, int pz, int rx, int ry, int rz,
                                   bit fend, bit empty);
        marker_t m;
        m.id = ID_W'(id);
        m.px = POS_W'(px);
        m.py = POS_W'(py);
        m.pz = POS_W'(pz);
        m.rx = ROT_W'(rx);
        m.ry = ROT_W'(ry);
        m.rz = ROT_W'(rz);
        m.fend = fend;
        m.empty = empty;
        mk = m;
    endfunction

    // coordinate near a center, clamped to the field range
    function automatic logic signed [15:0] near_coord(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        near_coord = 16'(v);
    endfunction

    task automatic push_marker(marker_t m);
        marker_queue.insert(marker_queue.size(), m);
        items_queued++;
    endtask

    // register write, with cfg_we dropped again between writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_cfg = data[RADIUS_W-1:0];
            CFG_TEAM_A: team_a_cfg = data[TEAM_W-1:0];
            CFG_TEAM_B: team_b_cfg = data[TEAM_W-1:0];
            default: ;
        endcase
    endtask

    // wait for every item taken and every selection seen, then let the block settle
    task automatic wait_drained();
        while (items_taken != items_queued || expected_sel.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random frame, mostly clustered markers with team ids
    task automatic queue_random_frame();
        int      n;
        int      spread;
        int      cx;
        int      cy;
        int      cz;
        bit      wide;
        bit      close_empty;
        marker_t m;
        n = ($urandom_range(99) < 8) ? int'($urandom_range(20, 17))
                                     : int'($urandom_range(6));
        wide = ($urandom_range(99) < 20);
        close_empty = ($urandom_range(99) < 15);
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = 3;
            2: spread = int'(radius_cfg) / 2 + 1;
            default: spread = int'(radius_cfg) + 50;
        endcase
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        cz = int'($urandom_range(60000)) - 30000;
        for (int k = 0; k < n; k++)
        begin
            // ignored filler with junk payload
            if ($urandom_range(99) < 10)
            begin
                m = mk(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), rand16(),
                       1'b0, 1'b1);
                push_marker(m);
            end
            case ($urandom_range(9))
                0, 1, 2, 3: m.id = team_a_cfg[ID_W-1:0];
                4, 5, 6:    m.id = team_b_cfg[ID_W-1:0];
                default:    m.id = ID_W'($urandom_range(1023));
            endcase
            if (wide)
            begin
                m.px = rand16();
                m.py = rand16();
                m.pz = rand16();
            end
            else
            begin
                m.px = near_coord(cx, spread);
                m.py = near_coord(cy, spread);
                m.pz = near_coord(cz, spread);
            end
            m.rx = rand16();
            m.ry = rand16();
            m.rz = rand16();
            m.empty = 1'b0;
            m.fend = (k == n - 1) && !close_empty;
            push_marker(m);
        end
        if (n == 0 || close_empty)
        begin
            m = mk(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), rand16(),
                   1'b1, 1'b1);
            push_marker(m);
        end
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 72;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 72;
            end
            default:
            begin
                send_idle_pct = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    // input driver, predicts on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_selection(marker_on_bus);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (marker_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    marker_on_bus = marker_queue.pop_front();
                    marker_id   <= marker_on_bus.id;
                    pos_x       <= marker_on_bus.px;
                    pos_y       <= marker_on_bus.py;
                    pos_z       <= marker_on_bus.pz;
                    rot_x       <= marker_on_bus.rx;
                    rot_y       <= marker_on_bus.ry;
                    rot_z       <= marker_on_bus.rz;
                    frame_end   <= marker_on_bus.fend;
                    empty_frame <= marker_on_bus.empty;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and random stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sel.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_LIMIT)
                    $display("%0t: selection transfer with nothing expected, id %0d found %0b",
                             $time, sel_id, found);
            end
            else
            begin
                sel_due = expected_sel.pop_front();
                check_field("sel_id", int'(sel_due.id), int'(sel_id));
                check_field("sel_pos_x", int'(sel_due.px), int'(sel_pos_x));
                check_field("sel_pos_y", int'(sel_due.py), int'(sel_pos_y));
                check_field("sel_pos_z", int'(sel_due.pz), int'(sel_pos_z));
                check_field("sel_rot_x", int'(sel_due.rx), int'(sel_rot_x));
                check_field("sel_rot_y", int'(sel_due.ry), int'(sel_rot_y));
                check_field("sel_rot_z", int'(sel_due.rz), int'(sel_rot_z));
                check_field("found", int'(sel_due.found), int'(found));
                check_field("last_sel", int'(sel_due.last), int'(last_sel));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [TEAM_W-1:0] ta;
        logic [TEAM_W-1:0] tb;
        logic [4:0]        pad_a;
        logic [4:0]        pad_b;
        logic [RADIUS_W-1:0] rad;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: empty frame, and ids that a negative team must not match
        set_idle_mode(0);
        push_marker(mk(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        push_marker(mk(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        push_marker(mk(1023, 0, 0, 10, 0, 0, 0, 1'b1, 1'b0));
        wait_drained();

        write_reg(CFG_UNUSED, 16'h0000);
        write_reg(CFG_RADIUS, 16'd500);
        write_reg(CFG_TEAM_A, 16'd5);
        write_reg(CFG_TEAM_B, 16'd1023);
        set_idle_mode(3);

        // cluster with far member, anchor without team id, distance tie
        push_marker(mk(5, 100, 0, 1000, 1, 2, 3, 1'b0, 1'b0));
        push_marker(mk(9, 0, 0, 900, 4, 5, 6, 1'b0, 1'b0));
        push_marker(mk(1023, 0, 300, 900, 7, 8, 9, 1'b0, 1'b0));
        push_marker(mk(5, 4000, 0, 950, 10, 11, 12, 1'b0, 1'b0));
        push_marker(mk(5, -100, 0, 1000, 13, 14, 15, 1'b1, 1'b0));
        // more matches than the output limit, arriving farthest first
        for (int k = 0; k < 6; k++)
            push_marker(mk(5, 0, 0, 15 - k, k, -k, 100 * k, k == 5, 1'b0));
        // filler item, then a lone marker at the field extremes
        push_marker(mk(5, 1, 1, 1, 1, 1, 1, 1'b0, 1'b1));
        push_marker(mk(1023, 32767, 32767, 32767, -32768, 32767, -32768, 1'b1, 1'b0));
        // most negative depth as anchor, far partner at the other extreme
        push_marker(mk(5, -32768, 32767, -32768, 32767, -32768, 32767, 1'b0, 1'b0));
        push_marker(mk(1023, 32767, -32768, 32767, -1, 0, -1, 1'b1, 1'b0));
        wait_drained();

        // random phases over register settings and idle patterns
        for (int i = 0; i < 6; i++)
        begin
            pad_a = 5'($urandom_range(31));
            pad_b = 5'($urandom_range(31));
            case (i)
                0:
                begin
                    rad = 16'd300;
                    ta = TEAM_W'($urandom_range(1023));
                    tb = TEAM_W'($urandom_range(1023));
                end
                1:
                begin
                    rad = 16'd0;
                    ta = 11'd0;
                    tb = 11'd1023;
                end
                2:
                begin
                    rad = 16'd65535;
                    ta = 11'd1023;
                    tb = '1;
                end
                3:
                begin
                    rad = 16'd2000;
                    ta = TEAM_W'($urandom_range(1023));
                    tb = TEAM_W'($urandom_range(1023));
                end
                4:
                begin
                    rad = rand16();
                    ta = '1;
                    tb = TEAM_W'($urandom_range(1023));
                end
                default:
                begin
                    rad = 16'd150;
                    ta = TEAM_W'($urandom_range(1023));
                    tb = ta;
                end
            endcase
            write_reg(CFG_RADIUS, rad);
            write_reg(CFG_TEAM_A, {pad_a, ta});
            write_reg(CFG_TEAM_B, {pad_b, tb});
            set_idle_mode(i % 4);
            begin
                int phase_start;
                phase_start = items_queued;
                while (items_queued - phase_start < 20)
                    queue_random_frame();
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
